// ===== hdl/stt_pkg.sv =====
// Shared types, codes and helpers for the station table tracker.
package stt_pkg;

  localparam int MAC_W     = 48;
  localparam int TIME_W    = 32;
  localparam int CNT_W     = 32;
  localparam int MCAST_BIT = 40;

  // Opcodes of the input channel
  localparam logic [1:0] OP_OBSERVE = 2'd0;
  localparam logic [1:0] OP_PURGE   = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  localparam logic [1:0] SRC_PROBE = 2'd1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STALE  = 1'd1;

  localparam logic [TIME_W-1:0] ACTIVE_RST = 32'd10000;
  localparam logic [TIME_W-1:0] STALE_RST  = 32'd60000;

  // Item classes decided by the front end
  typedef logic [2:0] cls_t;
  localparam cls_t CLS_OBS   = 3'd0;
  localparam cls_t CLS_REJ   = 3'd1;
  localparam cls_t CLS_PURGE = 3'd2;
  localparam cls_t CLS_CLEAR = 3'd3;
  localparam cls_t CLS_NOP   = 3'd4;

  typedef struct packed {
    cls_t               cls;
    logic [MAC_W-1:0]   client_mac;
    logic [MAC_W-1:0]   ap_mac;
    logic               ap_ok;
    logic signed [7:0]  rssi;
    logic [1:0]         source;
    logic [7:0]         channel;
    logic [TIME_W-1:0]  now_ms;
  } item_t;

  // One table entry as held in the RAM
  typedef struct packed {
    logic [MAC_W-1:0]   client_addr;
    logic [MAC_W-1:0]   ap_addr;
    logic [TIME_W-1:0]  last_seen;
    logic [CNT_W-1:0]   packet_count;
    logic [CNT_W-1:0]   probe_count;
    logic signed [7:0]  rssi_ema;
    logic signed [7:0]  rssi_low;
    logic signed [7:0]  rssi_high;
    logic [7:0]         last_channel;
    logic [1:0]         last_source;
    logic               is_idle;
  } entry_t;

  // floor((3*old + sample) / 4)
  function automatic logic signed [7:0] ema_step(input logic signed [7:0] old_v,
                                                 input logic signed [7:0] sample);
    logic signed [10:0] o;
    logic signed [10:0] s;
    logic signed [10:0] v;
    o = 11'(old_v);
    s = 11'(sample);
    v = o * 11'sd3 + s;
    return v[9:2];
  endfunction

endpackage

// ===== hdl/stt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module stt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/stt_front.sv =====
// Front end: takes input transfers, classifies them and queues them.
module stt_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_opcode,
  input  logic [stt_pkg::MAC_W-1:0] in_client_mac,
  input  logic [stt_pkg::MAC_W-1:0] in_ap_mac,
  input  logic                      in_ap_present,
  input  logic signed [7:0]         in_rssi,
  input  logic [1:0]                in_source,
  input  logic [7:0]                in_channel,
  input  logic [stt_pkg::TIME_W-1:0] in_now_ms,
  output logic                      q_valid,
  output stt_pkg::item_t            q_item,
  input  logic                      q_pop
);

  stt_pkg::item_t fifo_r [2];
  stt_pkg::item_t item;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       mac_ok;

  // Classification
  assign mac_ok = (in_client_mac != '0) && !in_client_mac[stt_pkg::MCAST_BIT];

  always_comb begin
    item.client_mac = in_client_mac;
    item.ap_mac     = in_ap_mac;
    item.ap_ok      = in_ap_present && (in_ap_mac != '0) && (in_ap_mac != '1);
    item.rssi       = in_rssi;
    item.source     = in_source;
    item.channel    = in_channel;
    item.now_ms     = in_now_ms;
    unique case (in_opcode)
      stt_pkg::OP_OBSERVE: item.cls = mac_ok ? stt_pkg::CLS_OBS : stt_pkg::CLS_REJ;
      stt_pkg::OP_PURGE:   item.cls = stt_pkg::CLS_PURGE;
      stt_pkg::OP_CLEAR:   item.cls = stt_pkg::CLS_CLEAR;
      default:             item.cls = stt_pkg::CLS_NOP;
    endcase
  end

  // Two-entry queue
  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = fifo_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ q_pop;
    count_nxt  = count_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= item;
    end
  end

endmodule

// ===== hdl/stt_back.sv =====
// Back end: scans the table RAM and carries out observe, purge and clear.
module stt_back #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       q_valid,
  input  stt_pkg::item_t             q_item,
  output logic                       q_pop,
  input  logic [stt_pkg::TIME_W-1:0] active_win,
  input  logic [stt_pkg::TIME_W-1:0] stale_win,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_accepted,
  output logic [4:0]                 out_slot,
  output logic                       out_was_hit,
  output logic                       out_replaced_oldest,
  output logic signed [7:0]          out_smoothed_rssi,
  output logic [5:0]                 out_purged_count,
  output logic [5:0]                 out_live_count
);

  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int EW = $bits(stt_pkg::entry_t);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_PICK = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]              state_r, state_nxt;
  stt_pkg::item_t          item_r, item_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    pv_r, pv_nxt;
  logic [IW-1:0]           pidx_r, pidx_nxt;
  logic [TABLE_ENTRIES-1:0] used_r, used_nxt;
  logic [CW-1:0]           live_r, live_nxt;
  logic [CW-1:0]           purged_r, purged_nxt;
  logic                    hit_f_r, hit_f_nxt;
  logic [IW-1:0]           hit_idx_r, hit_idx_nxt;
  logic                    free_f_r, free_f_nxt;
  logic [IW-1:0]           free_idx_r, free_idx_nxt;
  logic                    min_f_r, min_f_nxt;
  logic [IW-1:0]           min_idx_r, min_idx_nxt;
  logic [stt_pkg::TIME_W-1:0] min_val_r, min_val_nxt;
  logic [IW-1:0]           sel_idx_r, sel_idx_nxt;
  logic                    sel_new_r, sel_new_nxt;
  logic                    sel_repl_r, sel_repl_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_acc_r, out_acc_nxt;
  logic [4:0]              out_slot_r, out_slot_nxt;
  logic                    out_hit_r, out_hit_nxt;
  logic                    out_repl_r, out_repl_nxt;
  logic signed [7:0]       out_rssi_r, out_rssi_nxt;
  logic [5:0]              out_purged_r, out_purged_nxt;
  logic [5:0]              out_live_r, out_live_nxt;

  logic                    ram_we, ram_re;
  logic [IW-1:0]           ram_waddr, ram_raddr;
  logic [EW-1:0]           ram_wdata, ram_rdata;

  stt_pkg::entry_t         rd_e, base, upd;
  logic [stt_pkg::TIME_W-1:0] age;
  logic                    first;
  logic                    out_free;
  logic                    scan_used;
  logic [CW-1:0]           live_obs;

  stt_ram #(.WIDTH(EW), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_e      = stt_pkg::entry_t'(ram_rdata);
  assign out_free  = !out_valid_r || !out_stall;
  assign scan_used = used_r[pidx_r];
  assign age       = item_r.now_ms - rd_e.last_seen;

  // Entry update for an observation
  always_comb begin
    base  = sel_new_r ? '0 : rd_e;
    upd   = base;
    upd.client_addr  = item_r.client_mac;
    upd.packet_count = base.packet_count + 32'd1;
    upd.probe_count  = base.probe_count + 32'(item_r.source == stt_pkg::SRC_PROBE);
    upd.last_seen    = item_r.now_ms;
    upd.last_channel = item_r.channel;
    upd.last_source  = item_r.source;
    upd.is_idle      = 1'b0;
    first = (upd.packet_count == 32'd1);
    if (item_r.rssi != 8'sd0) begin
      if (first || item_r.rssi < base.rssi_low) begin
        upd.rssi_low = item_r.rssi;
      end
      if (first || item_r.rssi > base.rssi_high) begin
        upd.rssi_high = item_r.rssi;
      end
      upd.rssi_ema = first ? item_r.rssi : stt_pkg::ema_step(base.rssi_ema, item_r.rssi);
    end
    if (item_r.ap_ok) begin
      upd.ap_addr = item_r.ap_mac;
    end
  end

  assign live_obs = live_r + CW'(sel_new_r && !sel_repl_r);

  // Sequencer
  always_comb begin
    state_nxt    = state_r;
    item_nxt     = item_r;
    cnt_nxt      = cnt_r;
    pv_nxt       = 1'b0;
    pidx_nxt     = pidx_r;
    used_nxt     = used_r;
    live_nxt     = live_r;
    purged_nxt   = purged_r;
    hit_f_nxt    = hit_f_r;
    hit_idx_nxt  = hit_idx_r;
    free_f_nxt   = free_f_r;
    free_idx_nxt = free_idx_r;
    min_f_nxt    = min_f_r;
    min_idx_nxt  = min_idx_r;
    min_val_nxt  = min_val_r;
    sel_idx_nxt  = sel_idx_r;
    sel_new_nxt  = sel_new_r;
    sel_repl_nxt = sel_repl_r;
    q_pop        = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = pidx_r;
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = cnt_r[IW-1:0];

    out_valid_nxt  = out_valid_r && out_stall;
    out_acc_nxt    = out_acc_r;
    out_slot_nxt   = out_slot_r;
    out_hit_nxt    = out_hit_r;
    out_repl_nxt   = out_repl_r;
    out_rssi_nxt   = out_rssi_r;
    out_purged_nxt = out_purged_r;
    out_live_nxt   = out_live_r;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          item_nxt   = q_item;
          cnt_nxt    = '0;
          purged_nxt = '0;
          hit_f_nxt  = 1'b0;
          free_f_nxt = 1'b0;
          min_f_nxt  = 1'b0;
          unique case (q_item.cls) inside
            stt_pkg::CLS_OBS, stt_pkg::CLS_PURGE: state_nxt = S_SCAN;
            stt_pkg::CLS_CLEAR: begin
              used_nxt  = '0;
              live_nxt  = '0;
              state_nxt = S_FIN;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end

      S_SCAN: begin
        // issue one read a cycle
        if (cnt_r < CW'(TABLE_ENTRIES)) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_r[IW-1:0];
          pv_nxt    = 1'b1;
          pidx_nxt  = cnt_r[IW-1:0];
          cnt_nxt   = cnt_r + CW'(1);
        end
        // evaluate the entry read last cycle
        if (pv_r) begin
          if (item_r.cls == stt_pkg::CLS_OBS) begin
            if (scan_used && rd_e.client_addr == item_r.client_mac && !hit_f_r) begin
              hit_f_nxt   = 1'b1;
              hit_idx_nxt = pidx_r;
            end
            if (!scan_used && !free_f_r) begin
              free_f_nxt   = 1'b1;
              free_idx_nxt = pidx_r;
            end
            if (scan_used && (!min_f_r || rd_e.last_seen < min_val_r)) begin
              min_f_nxt   = 1'b1;
              min_idx_nxt = pidx_r;
              min_val_nxt = rd_e.last_seen;
            end
          end else if (scan_used) begin
            if (age > active_win) begin
              ram_we    = 1'b1;
              ram_waddr = pidx_r;
              ram_wdata = {ram_rdata[EW-1:1], 1'b1};
            end
            if (age > stale_win) begin
              used_nxt[pidx_r] = 1'b0;
              purged_nxt       = purged_r + CW'(1);
              live_nxt         = live_r - CW'(1);
            end
          end
        end
        if (cnt_r == CW'(TABLE_ENTRIES) && !pv_r) begin
          state_nxt = (item_r.cls == stt_pkg::CLS_OBS) ? S_PICK : S_FIN;
        end
      end

      S_PICK: begin
        if (hit_f_r) begin
          sel_idx_nxt  = hit_idx_r;
          sel_new_nxt  = 1'b0;
          sel_repl_nxt = 1'b0;
        end else if (free_f_r) begin
          sel_idx_nxt  = free_idx_r;
          sel_new_nxt  = 1'b1;
          sel_repl_nxt = 1'b0;
        end else begin
          sel_idx_nxt  = min_idx_r;
          sel_new_nxt  = 1'b1;
          sel_repl_nxt = 1'b1;
        end
        ram_re    = 1'b1;
        ram_raddr = sel_idx_nxt;
        state_nxt = S_UPD;
      end

      S_UPD: begin
        if (out_free) begin
          ram_we              = 1'b1;
          ram_waddr           = sel_idx_r;
          ram_wdata           = EW'(upd);
          used_nxt[sel_idx_r] = 1'b1;
          live_nxt            = live_obs;
          out_valid_nxt       = 1'b1;
          out_acc_nxt         = 1'b1;
          out_slot_nxt        = 5'(sel_idx_r);
          out_hit_nxt         = !sel_new_r;
          out_repl_nxt        = sel_repl_r;
          out_rssi_nxt        = upd.rssi_ema;
          out_purged_nxt      = '0;
          out_live_nxt        = 6'(live_obs);
          state_nxt           = S_IDLE;
        end
      end

      S_FIN: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_acc_nxt    = 1'b0;
          out_slot_nxt   = '0;
          out_hit_nxt    = 1'b0;
          out_repl_nxt   = 1'b0;
          out_rssi_nxt   = '0;
          out_purged_nxt = (item_r.cls == stt_pkg::CLS_PURGE) ? 6'(purged_r) : 6'd0;
          out_live_nxt   = 6'(live_r);
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pv_r        <= 1'b0;
      used_r      <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pv_r        <= pv_nxt;
      used_r      <= used_nxt;
      live_r      <= live_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and scan bookkeeping
  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    cnt_r        <= cnt_nxt;
    pidx_r       <= pidx_nxt;
    purged_r     <= purged_nxt;
    hit_f_r      <= hit_f_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_f_r     <= free_f_nxt;
    free_idx_r   <= free_idx_nxt;
    min_f_r      <= min_f_nxt;
    min_idx_r    <= min_idx_nxt;
    min_val_r    <= min_val_nxt;
    sel_idx_r    <= sel_idx_nxt;
    sel_new_r    <= sel_new_nxt;
    sel_repl_r   <= sel_repl_nxt;
    out_acc_r    <= out_acc_nxt;
    out_slot_r   <= out_slot_nxt;
    out_hit_r    <= out_hit_nxt;
    out_repl_r   <= out_repl_nxt;
    out_rssi_r   <= out_rssi_nxt;
    out_purged_r <= out_purged_nxt;
    out_live_r   <= out_live_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_accepted        = out_acc_r;
  assign out_slot            = out_slot_r;
  assign out_was_hit         = out_hit_r;
  assign out_replaced_oldest = out_repl_r;
  assign out_smoothed_rssi   = out_rssi_r;
  assign out_purged_count    = out_purged_r;
  assign out_live_count      = out_live_r;

endmodule

// ===== hdl/station_table_tracker_top.sv =====
// Top level of the station table tracker: config registers, front end and back end.
//
// Tracks up to TABLE_ENTRIES client MAC entries in a table RAM with one read and
// one write port and one valid flip-flop per slot. Observe and purge both scan
// the table, reading one table entry per cycle through the RAM read port; clear,
// a rejected MAC and opcode three skip the scan. A two-entry queue sits in front
// of the engine and the result is held in an output register, so new transfers
// are taken while a result waits. Items are worked one at a time.
module station_table_tracker_top #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [stt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                 cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_opcode,
  input  logic [47:0]                 in_client_mac,
  input  logic [47:0]                 in_ap_mac,
  input  logic                        in_ap_present,
  input  logic signed [7:0]           in_rssi,
  input  logic [1:0]                  in_source,
  input  logic [7:0]                  in_channel,
  input  logic [31:0]                 in_now_ms,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_accepted,
  output logic [4:0]                  out_slot,
  output logic                        out_was_hit,
  output logic                        out_replaced_oldest,
  output logic signed [7:0]           out_smoothed_rssi,
  output logic [5:0]                  out_purged_count,
  output logic [5:0]                  out_live_count
);

  logic [31:0]    active_r, active_nxt;
  logic [31:0]    stale_r, stale_nxt;
  logic           q_valid;
  logic           q_pop;
  stt_pkg::item_t q_item;

  // Configuration registers
  always_comb begin
    active_nxt = active_r;
    stale_nxt  = stale_r;
    if (cfg_we) begin
      unique case (cfg_index)
        stt_pkg::REG_ACTIVE: active_nxt = cfg_data;
        stt_pkg::REG_STALE:  stale_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= stt_pkg::ACTIVE_RST;
      stale_r  <= stt_pkg::STALE_RST;
    end else begin
      active_r <= active_nxt;
      stale_r  <= stale_nxt;
    end
  end

  stt_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_client_mac (in_client_mac),
    .in_ap_mac     (in_ap_mac),
    .in_ap_present (in_ap_present),
    .in_rssi       (in_rssi),
    .in_source     (in_source),
    .in_channel    (in_channel),
    .in_now_ms     (in_now_ms),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop)
  );

  stt_back #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_valid),
    .q_item              (q_item),
    .q_pop               (q_pop),
    .active_win          (active_r),
    .stale_win           (stale_r),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_accepted        (out_accepted),
    .out_slot            (out_slot),
    .out_was_hit         (out_was_hit),
    .out_replaced_oldest (out_replaced_oldest),
    .out_smoothed_rssi   (out_smoothed_rssi),
    .out_purged_count    (out_purged_count),
    .out_live_count      (out_live_count)
  );

endmodule

// ===== dv/station_table_tracker_top_tb.sv =====
// Self-checking testbench for the station table tracker top level.
`timescale 1ns / 1ps

module station_table_tracker_top_tb;

  localparam int N = 32;
  localparam int CYCLE_LIMIT = 400000;
  // Opcode three does nothing to the table
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  opcode;
    logic [47:0] client_mac;
    logic [47:0] ap_mac;
    logic        ap_present;
    logic [7:0]  rssi;
    logic [1:0]  source;
    logic [7:0]  channel;
    logic [31:0] now_ms;
  } obs_item_t;

  typedef struct {
    logic        accepted;
    logic [4:0]  slot;
    logic        was_hit;
    logic        replaced_oldest;
    logic [7:0]  smoothed_rssi;
    logic [5:0]  purged_count;
    logic [5:0]  live_count;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [stt_pkg::CFG_IDX_W-1:0] cfg_index = stt_pkg::REG_ACTIVE;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic [47:0] in_client_mac = '0;
  logic [47:0] in_ap_mac = '0;
  logic in_ap_present = 1'b0;
  logic signed [7:0] in_rssi = '0;
  logic [1:0] in_source = '0;
  logic [7:0] in_channel = '0;
  logic [31:0] in_now_ms = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_accepted;
  logic [4:0] out_slot;
  logic out_was_hit;
  logic out_replaced_oldest;
  logic signed [7:0] out_smoothed_rssi;
  logic [5:0] out_purged_count;
  logic [5:0] out_live_count;

  station_table_tracker_top dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the table
  logic [31:0] shadow_stale;
  logic        sh_used  [N];
  logic [47:0] sh_mac   [N];
  logic [31:0] sh_seen  [N];
  logic [31:0] sh_pkts  [N];
  logic signed [7:0] sh_ema [N];
  logic signed [7:0] sh_lo  [N];
  logic signed [7:0] sh_hi  [N];

  obs_item_t     pending_items[$];
  table_result_t expected_results[$];
  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int cycles = 0;
  logic sender_hold = 1'b0;

  function automatic table_result_t predict_table(obs_item_t it);
    table_result_t r;
    int idx, oldest, live;
    logic signed [7:0] rs;
    logic signed [10:0] v;
    logic [31:0] age;
    r = '{default: '0};
    rs = it.rssi;
    if (it.opcode == stt_pkg::OP_OBSERVE) begin
      if (it.client_mac != 0 && !it.client_mac[stt_pkg::MCAST_BIT]) begin
        idx = -1;
        for (int i = 0; i < N; i++)
          if (idx < 0 && sh_used[i] && sh_mac[i] == it.client_mac) idx = i;
        if (idx >= 0) begin
          r.was_hit = 1'b1;
        end else begin
          oldest = 0;
          for (int i = 0; i < N; i++) begin
            if (idx < 0) begin
              if (!sh_used[i]) idx = i;
              else if (sh_seen[i] < sh_seen[oldest]) oldest = i;
            end
          end
          if (idx < 0) begin
            idx = oldest;
            r.replaced_oldest = 1'b1;
          end
          sh_used[idx] = 1'b1;
          sh_mac[idx] = it.client_mac;
          sh_pkts[idx] = 0;
          sh_ema[idx] = 0;
          sh_lo[idx] = 0;
          sh_hi[idx] = 0;
        end
        sh_pkts[idx] = sh_pkts[idx] + 1;
        sh_seen[idx] = it.now_ms;
        if (rs != 0) begin
          if (sh_pkts[idx] == 1) begin
            sh_lo[idx] = rs;
            sh_hi[idx] = rs;
            sh_ema[idx] = rs;
          end else begin
            if (rs < sh_lo[idx]) sh_lo[idx] = rs;
            if (rs > sh_hi[idx]) sh_hi[idx] = rs;
            v = 11'(sh_ema[idx]) * 3 + 11'(rs);
            sh_ema[idx] = v[9:2];
          end
        end
        r.accepted = 1'b1;
        r.slot = idx[4:0];
        r.smoothed_rssi = sh_ema[idx];
      end
    end else if (it.opcode == stt_pkg::OP_PURGE) begin
      for (int i = 0; i < N; i++) begin
        if (sh_used[i]) begin
          age = it.now_ms - sh_seen[i];
          if (age > shadow_stale) begin
            sh_used[i] = 1'b0;
            r.purged_count++;
          end
        end
      end
    end else if (it.opcode == stt_pkg::OP_CLEAR) begin
      for (int i = 0; i < N; i++) sh_used[i] = 1'b0;
    end
    live = 0;
    for (int i = 0; i < N; i++) if (sh_used[i]) live++;
    r.live_count = live[5:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    $display("ERROR result %0d: %s got %0h expected %0h", results_seen, what, got, want);
  endtask

  // Driver: bursts with random gaps
  int gap_left = 0, burst_left = 0;
  always @(posedge clk) begin
    logic valid_nxt;
    obs_item_t it;
    valid_nxt = in_valid;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        valid_nxt = 1'b0;
        items_sent++;
      end
      if (!valid_nxt) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_items.size() > 0 && !sender_hold) begin
          it = pending_items.pop_front();
          expected_results.push_back(predict_table(it));
          valid_nxt = 1'b1;
          in_opcode <= it.opcode;
          in_client_mac <= it.client_mac;
          in_ap_mac <= it.ap_mac;
          in_ap_present <= it.ap_present;
          in_rssi <= it.rssi;
          in_source <= it.source;
          in_channel <= it.channel;
          in_now_ms <= it.now_ms;
          if (burst_left > 0) begin
            burst_left <= burst_left - 1;
          end else begin
            burst_left <= $urandom_range(12);
            gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(40);
          end
        end
      end
    end
    in_valid <= valid_nxt;
  end

  // Receiver stall pattern and result check
  logic [7:0] stall_phase = '0;
  always @(posedge clk) begin
    table_result_t w;
    cycles <= cycles + 1;
    stall_phase <= stall_phase + 1;
    out_stall <= (stall_phase[7:6] == 2'd1) ? 1'b0 : ($urandom_range(3) == 0);
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transfer", 0, 0);
      end else begin
        w = expected_results.pop_front();
        if (out_accepted !== w.accepted) report_mismatch("accepted", out_accepted, w.accepted);
        if (out_slot !== w.slot) report_mismatch("slot", out_slot, w.slot);
        if (out_was_hit !== w.was_hit) report_mismatch("was_hit", out_was_hit, w.was_hit);
        if (out_replaced_oldest !== w.replaced_oldest)
          report_mismatch("replaced_oldest", out_replaced_oldest, w.replaced_oldest);
        if (out_smoothed_rssi !== w.smoothed_rssi)
          report_mismatch("smoothed_rssi", out_smoothed_rssi, w.smoothed_rssi);
        if (out_purged_count !== w.purged_count)
          report_mismatch("purged_count", out_purged_count, w.purged_count);
        if (out_live_count !== w.live_count)
          report_mismatch("live_count", out_live_count, w.live_count);
      end
      results_seen++;
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Pool of unicast client addresses so that hits and evictions happen
  logic [47:0] mac_pool[48];
  logic [31:0] clock_ms = 32'd1000;

  function automatic obs_item_t make_item(logic [1:0] op, logic [47:0] mac,
                                         logic [31:0] now);
    obs_item_t it;
    it.opcode = op;
    it.client_mac = mac;
    it.ap_mac = 48'({$urandom, $urandom});
    it.ap_present = 1'($urandom);
    it.rssi = ($urandom_range(4) == 0) ? 8'd0 : 8'($urandom);
    it.source = 2'($urandom);
    it.channel = 8'($urandom);
    it.now_ms = now;
    return it;
  endfunction

  task automatic wait_drained();
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_reg(input logic [stt_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == stt_pkg::REG_STALE) shadow_stale = val;
  endtask

  initial begin
    obs_item_t it;
    logic [47:0] m;
    shadow_stale = stt_pkg::STALE_RST;
    for (int i = 0; i < N; i++) begin
      sh_used[i] = 1'b0; sh_seen[i] = 0; sh_mac[i] = 0; sh_pkts[i] = 0;
      sh_ema[i] = 0; sh_lo[i] = 0; sh_hi[i] = 0;
    end
    for (int i = 0; i < 48; i++) begin
      m = 48'({$urandom, $urandom});
      m[stt_pkg::MCAST_BIT] = 1'b0;
      if (i == 0) m = 48'hFEFF_FFFF_FFFF;
      if (m == 0) m = 48'h1;
      mac_pool[i] = m;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: rejected MACs, AP edge values, RSSI extremes, all opcodes
    pending_items.push_back(make_item(stt_pkg::OP_OBSERVE, 48'h0, 32'd10));
    pending_items.push_back(make_item(stt_pkg::OP_OBSERVE, 48'hFFFF_FFFF_FFFF, 32'd10));
    pending_items.push_back(make_item(stt_pkg::OP_OBSERVE, 48'h0100_0000_0001, 32'd10));
    it = make_item(stt_pkg::OP_OBSERVE, mac_pool[0], 32'hFFFF_FFFF);
    it.rssi = 8'h80; it.ap_present = 1'b1; it.ap_mac = 48'hFFFF_FFFF_FFFF;
    pending_items.push_back(it);
    it.rssi = 8'h7F; it.ap_mac = 48'h0; it.source = stt_pkg::SRC_PROBE;
    pending_items.push_back(it);
    it.rssi = 8'h00; it.ap_mac = 48'h0100_0000_0000;
    pending_items.push_back(it);
    it = make_item(stt_pkg::OP_OBSERVE, mac_pool[1], 32'd0);
    it.rssi = 8'h00;
    pending_items.push_back(it);
    pending_items.push_back(make_item(OP_UNUSED, mac_pool[2], 32'd5));
    pending_items.push_back(make_item(stt_pkg::OP_PURGE, 48'h0, 32'd100000));
    pending_items.push_back(make_item(stt_pkg::OP_CLEAR, 48'h0, 32'd0));
    // Fill all slots at 0xFFFFFFFF, then one more to evict slot 0 on the tie
    for (int i = 0; i < N + 1; i++)
      pending_items.push_back(make_item(stt_pkg::OP_OBSERVE, mac_pool[i], 32'hFFFF_FFFF));
    wait_drained();

    // Random phases over several window settings, extremes among them
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(stt_pkg::REG_ACTIVE, 32'd0);
          write_reg(stt_pkg::REG_STALE, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(stt_pkg::REG_ACTIVE, 32'hFFFF_FFFF);
          write_reg(stt_pkg::REG_STALE, 32'd0);
        end
        default: begin
          write_reg(stt_pkg::REG_ACTIVE, $urandom_range(3000));
          write_reg(stt_pkg::REG_STALE, $urandom_range(6000));
        end
      endcase
      for (int k = 0; k < 100; k++) begin
        clock_ms = clock_ms + (($urandom_range(9) == 0) ? $urandom : $urandom_range(400));
        case ($urandom_range(19))
          0, 1: pending_items.push_back(make_item(stt_pkg::OP_PURGE,
                                                  48'({$urandom, $urandom}), clock_ms));
          2: pending_items.push_back(make_item(($urandom_range(1) ? stt_pkg::OP_CLEAR
                                                                   : OP_UNUSED),
                                               48'({$urandom, $urandom}), clock_ms));
          3: pending_items.push_back(make_item(stt_pkg::OP_OBSERVE,
                                               48'({$urandom, $urandom}), clock_ms));
          default: pending_items.push_back(
                     make_item(stt_pkg::OP_OBSERVE, mac_pool[$urandom_range(47)], clock_ms));
        endcase
      end
      if (ph == 3) begin
        // Hold the sender until every outstanding result has arrived
        while (pending_items.size() > 50) @(posedge clk);
        sender_hold = 1'b1;
        while (in_valid || expected_results.size() > 0) @(posedge clk);
        sender_hold = 1'b0;
      end
      wait_drained();
    end

    $display("Covered %0d transfers: rejects, hits, fills, tie and oldest evictions,", items_sent);
    $display("purges over six window settings, clears and the unused opcode.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
